@@ rtl/kis_pkg.sv @@
package kis_pkg;

	localparam int TAG_BITS     = 6;
	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS_DEF = 63;

	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctl_t;

endpackage

@@ rtl/kis_cell.sv @@
module kis_cell #(
	parameter int KEY_BITS = kis_pkg::KEY_BITS_DEF
) (
	input  logic                        clk,
	input  kis_pkg::cell_ctl_t          ctl,
	input  logic                        occ,
	input  logic                        prev_occ,
	input  logic                        prev_gt,
	input  logic [KEY_BITS-1:0]         in_key,
	input  logic [kis_pkg::TAG_BITS-1:0] in_tag,
	input  logic [KEY_BITS-1:0]         prev_key,
	input  logic [kis_pkg::TAG_BITS-1:0] prev_tag,
	input  logic [KEY_BITS-1:0]         next_key,
	input  logic [kis_pkg::TAG_BITS-1:0] next_tag,
	output logic [KEY_BITS-1:0]         key,
	output logic [kis_pkg::TAG_BITS-1:0] tag,
	output logic                        gt
);

	logic [KEY_BITS-1:0]          key_q;
	logic [kis_pkg::TAG_BITS-1:0] tag_q;
	logic                         move;

	// A cell moves on insertion when its key is greater than the new one, or when it is
	// the first empty cell. It then takes its neighbour's item if that one also moves.
	assign gt   = occ && (key_q > in_key);
	assign move = gt || (!occ && prev_occ);

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q <= next_key;
			tag_q <= next_tag;
		end else if (ctl.ins && move) begin
			key_q <= prev_gt ? prev_key : in_key;
			tag_q <= prev_gt ? prev_tag : in_tag;
		end
	end

	assign key = key_q;
	assign tag = tag_q;

endmodule

@@ rtl/key_index_sorter.sv @@
// Channel  Direction  Handshake          tdata                      tlast         tuser
// s_*      in         s_tvalid/s_tready  sort_key, tag              batch_end     -
// m_*      out        m_tvalid/m_tready  sorted_key, sorted_tag     final_result  overflowed
//
// Loading takes one item per cycle; each item is placed in order across the row of cells.
// After the item marked last, the batch of stored items leaves one per cycle while m_tready
// stays high; input is held off from that item until the final item is registered on the
// output. No clearing pass follows reset. A stall on m_tready during the drain freezes the
// row of cells.
module key_index_sorter #(
	parameter  int CAPACITY = kis_pkg::CAPACITY_DEF,
	parameter  int KEY_BITS = kis_pkg::KEY_BITS_DEF,
	localparam int DW       = ((KEY_BITS + kis_pkg::TAG_BITS + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [DW-1:0] s_tdata,   // sort_key, tag
	input  logic          s_tlast,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [DW-1:0] m_tdata,   // sorted_key, sorted_tag
	output logic          m_tlast,
	output logic          m_tuser    // overflowed
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int TB = kis_pkg::TAG_BITS;

	logic [CW-1:0]       fill_q;
	logic                drain_q;
	logic                ovf_seen_q;
	logic                out_valid_q;
	logic [KEY_BITS-1:0] out_key_q;
	logic [TB-1:0]       out_tag_q;
	logic                out_last_q;
	logic                out_ovf_q;

	logic                in_acc;
	logic                full;
	logic                load_out;
	logic                last_one;
	kis_pkg::cell_ctl_t  ctl;
	logic [KEY_BITS-1:0] in_key;
	logic [TB-1:0]       in_tag;

	logic [KEY_BITS-1:0] ck  [CAPACITY];
	logic [TB-1:0]       ct  [CAPACITY];
	logic                cgt [CAPACITY];
	logic                occ [CAPACITY];

	assign in_key   = s_tdata[KEY_BITS-1:0];
	assign in_tag   = s_tdata[KEY_BITS+TB-1:KEY_BITS];
	assign s_tready = !drain_q;
	assign in_acc   = s_tvalid && s_tready;
	assign full     = (fill_q == CW'(CAPACITY));
	assign load_out = drain_q && (!out_valid_q || m_tready);
	assign last_one = (fill_q == CW'(1));
	assign ctl.ins   = in_acc && !full;
	assign ctl.shift = load_out;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign occ[i] = (fill_q > CW'(i));
		if (i == 0) begin : g_head
			kis_cell #(.KEY_BITS(KEY_BITS)) u_cell (
				.clk(clk), .ctl(ctl), .occ(occ[i]), .prev_occ(1'b1), .prev_gt(1'b0),
				.in_key(in_key), .in_tag(in_tag), .prev_key(in_key), .prev_tag(in_tag),
				.next_key(ck[i+1]), .next_tag(ct[i+1]),
				.key(ck[i]), .tag(ct[i]), .gt(cgt[i])
			);
		end else if (i == CAPACITY - 1) begin : g_tail
			kis_cell #(.KEY_BITS(KEY_BITS)) u_cell (
				.clk(clk), .ctl(ctl), .occ(occ[i]), .prev_occ(occ[i-1]),
				.prev_gt(cgt[i-1]), .in_key(in_key), .in_tag(in_tag),
				.prev_key(ck[i-1]), .prev_tag(ct[i-1]),
				.next_key(ck[i]), .next_tag(ct[i]),
				.key(ck[i]), .tag(ct[i]), .gt(cgt[i])
			);
		end else begin : g_mid
			kis_cell #(.KEY_BITS(KEY_BITS)) u_cell (
				.clk(clk), .ctl(ctl), .occ(occ[i]), .prev_occ(occ[i-1]),
				.prev_gt(cgt[i-1]), .in_key(in_key), .in_tag(in_tag),
				.prev_key(ck[i-1]), .prev_tag(ct[i-1]),
				.next_key(ck[i+1]), .next_tag(ct[i+1]),
				.key(ck[i]), .tag(ct[i]), .gt(cgt[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			drain_q     <= 1'b0;
			ovf_seen_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.ins) begin
				fill_q <= fill_q + CW'(1);
			end else if (load_out) begin
				fill_q <= fill_q - CW'(1);
			end
			if (in_acc && full) begin
				ovf_seen_q <= 1'b1;
			end else if (load_out && last_one) begin
				ovf_seen_q <= 1'b0;
			end
			if (in_acc && s_tlast) begin
				drain_q <= 1'b1;
			end else if (load_out && last_one) begin
				drain_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_key_q  <= ck[0];
			out_tag_q  <= ct[0];
			out_last_q <= last_one;
			out_ovf_q  <= ovf_seen_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = DW'({out_tag_q, out_key_q});
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

endmodule

@@ rtl/kis_check.sv @@
module kis_check #(
	parameter  int CAPACITY = kis_pkg::CAPACITY_DEF,
	parameter  int KEY_BITS = kis_pkg::KEY_BITS_DEF,
	localparam int DW       = ((KEY_BITS + kis_pkg::TAG_BITS + 7) / 8) * 8
) (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tvalid,
	input logic          s_tready,
	input logic [DW-1:0] s_tdata,
	input logic          s_tlast,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [DW-1:0] m_tdata,
	input logic          m_tlast,
	input logic          m_tuser
);

	a_hold_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("Input was not held off after the last item of a batch.");

	a_busy_mid_batch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("Input accepted while a batch is still being emitted.");

	a_flag_steady: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !m_tvalid || $stable(m_tuser))
		else $error("Overflow flag changed within one batch.");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Stalled output transfer was not held.");

endmodule

bind key_index_sorter kis_check #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_kis_check (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.s_tdata(s_tdata), .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser)
);

@@ dv/tb_key_index_sorter.sv @@
module tb_key_index_sorter;

	localparam int TAG_BITS = kis_pkg::TAG_BITS;
	localparam int KB  = kis_pkg::KEY_BITS_DEF;
	localparam int CAP = kis_pkg::CAPACITY_DEF;
	localparam int DW  = ((KB + TAG_BITS + 7) / 8) * 8;

	localparam logic [KB-1:0] KEY_MAX = {KB{1'b1}};
	localparam logic [KB-1:0] KEY_TOP = {1'b1, {(KB-1){1'b0}}};
	localparam logic [KB-1:0] KEY_A   = 63'h2AAA_AAAA_AAAA_AAAA;
	localparam logic [KB-1:0] KEY_5   = 63'h5555_5555_5555_5555;

	typedef struct packed {
		logic [KB-1:0]       key;
		logic [TAG_BITS-1:0] tag;
		logic                last_res;
		logic                ovf;
	} sorted_rec_t;

	typedef struct packed {
		logic [KB-1:0]       key;
		logic [TAG_BITS-1:0] tag;
		logic                last;
		logic                typed;
		sorted_rec_t         want;
	} dir_row_t;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [DW-1:0] s_tdata;   // sort_key, tag
	logic          s_tlast;
	logic          m_tvalid;
	logic          m_tready;
	logic [DW-1:0] m_tdata;   // sorted_key, sorted_tag
	logic          m_tlast;
	logic          m_tuser;   // overflowed

	logic [KB-1:0]       held_keys [CAP];
	logic [TAG_BITS-1:0] held_tags [CAP];
	int                  held_count;
	bit                  dropped_seen;
	sorted_rec_t         pending_sorted[$];

	int  idle_pct;
	int  stall_pct;
	bit  hold_req;
	int  mismatches;
	int  items_sent;
	int  results_seen;
	int  batches_done;
	int  overflow_batches;

	dir_row_t dir_tab [18] = '{
		'{KEY_MAX, 6'd63, 1'b1, 1'b1, '{KEY_MAX, 6'd63, 1'b1, 1'b0}},
		'{'0,      6'd0,  1'b1, 1'b1, '{'0,      6'd0,  1'b1, 1'b0}},
		'{KEY_TOP, 6'h20, 1'b1, 1'b1, '{KEY_TOP, 6'h20, 1'b1, 1'b0}},
		'{63'd100, 6'd1,  1'b0, 1'b0, '0},
		'{63'd50,  6'd2,  1'b0, 1'b0, '0},
		'{KEY_MAX, 6'd3,  1'b0, 1'b0, '0},
		'{'0,      6'd4,  1'b0, 1'b0, '0},
		'{63'd50,  6'd5,  1'b1, 1'b0, '0},
		'{63'd1,   6'd6,  1'b0, 1'b0, '0},
		'{63'd2,   6'd7,  1'b0, 1'b0, '0},
		'{63'd3,   6'd8,  1'b0, 1'b0, '0},
		'{63'd4,   6'd9,  1'b1, 1'b0, '0},
		'{63'd77,  6'd10, 1'b0, 1'b0, '0},
		'{63'd77,  6'd11, 1'b0, 1'b0, '0},
		'{63'd77,  6'd12, 1'b0, 1'b0, '0},
		'{63'd77,  6'd13, 1'b1, 1'b0, '0},
		'{KEY_A,   6'h2A, 1'b0, 1'b0, '0},
		'{KEY_5,   6'h15, 1'b1, 1'b0, '0}
	};

	key_index_sorter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 200000);
		$display("Timeout with %0d sorted results still awaited.", pending_sorted.size());
		$display("TEST FAILED");
		$finish;
	end

	// Insertion after every stored key that is less than or equal keeps equal keys in
	// arrival order; the final item releases the whole batch.
	task automatic predict_sorted(input logic [KB-1:0] key, input logic [TAG_BITS-1:0] tag,
			input logic last);
		int          pos;
		int          k;
		sorted_rec_t rec;
		if (held_count < CAP) begin
			pos = held_count;
			while (pos > 0 && held_keys[pos-1] > key) begin
				held_keys[pos] = held_keys[pos-1];
				held_tags[pos] = held_tags[pos-1];
				pos--;
			end
			held_keys[pos] = key;
			held_tags[pos] = tag;
			held_count++;
		end else begin
			dropped_seen = 1'b1;
		end
		if (last) begin
			for (k = 0; k < held_count; k++) begin
				rec.key      = held_keys[k];
				rec.tag      = held_tags[k];
				rec.last_res = (k + 1 == held_count);
				rec.ovf      = dropped_seen;
				pending_sorted.insert(pending_sorted.size(), rec);
			end
			held_count   = 0;
			dropped_seen = 1'b0;
		end
	endtask

	task automatic send_item(input logic [KB-1:0] key, input logic [TAG_BITS-1:0] tag,
			input logic last);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(DW-KB-TAG_BITS){1'b0}}, tag, key};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		predict_sorted(key, tag, last);
		items_sent++;
	endtask

	function automatic logic [KB-1:0] random_key();
		logic [63:0] wide;
		int unsigned pick;
		wide = {$urandom, $urandom};
		pick = $urandom_range(9);
		if (pick < 4)
			return wide[KB-1:0];
		else if (pick < 7)
			return KB'($urandom_range(7));
		else if (pick == 7)
			return KEY_MAX - KB'($urandom_range(3));
		else if (pick == 8)
			return KB'($urandom_range(3));
		return KB'(1) << $urandom_range(KB - 1);
	endfunction

	initial begin : receiver
		int held;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				for (held = 0; held < 400; held++)
					@(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		sorted_rec_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_sorted.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transfer key %h tag %h last %b overflow %b", $time,
					m_tdata[KB-1:0], m_tdata[KB+TAG_BITS-1:KB], m_tlast, m_tuser);
			end else begin
				want = pending_sorted.pop_front();
				if (m_tdata[KB-1:0] !== want.key) begin
					mismatches++;
					$display("%0t: sorted_key expected %h got %h", $time, want.key,
						m_tdata[KB-1:0]);
				end
				if (m_tdata[KB+TAG_BITS-1:KB] !== want.tag) begin
					mismatches++;
					$display("%0t: sorted_tag expected %h got %h", $time, want.tag,
						m_tdata[KB+TAG_BITS-1:KB]);
				end
				if (m_tlast !== want.last_res) begin
					mismatches++;
					$display("%0t: final_result expected %b got %b", $time, want.last_res,
						m_tlast);
				end
				if (m_tuser !== want.ovf) begin
					mismatches++;
					$display("%0t: overflowed expected %b got %b", $time, want.ovf, m_tuser);
				end
				if (want.last_res) begin
					batches_done++;
					if (want.ovf)
						overflow_batches++;
				end
			end
		end
	end

	initial begin : stimulus
		int          r;
		int          batch_no;
		int          batch_len;
		int          n;
		sorted_rec_t typed_rec;
		held_count   = 0;
		dropped_seen = 1'b0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_req     = 1'b0;
		mismatches   = 0;
		items_sent   = 0;
		results_seen = 0;
		batches_done = 0;
		overflow_batches = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < $size(dir_tab); r++) begin
			send_item(dir_tab[r].key, dir_tab[r].tag, dir_tab[r].last);
			if (dir_tab[r].typed) begin
				typed_rec = dir_tab[r].want;
				pending_sorted[pending_sorted.size() - 1] = typed_rec;
			end
		end

		// Phases rotate per batch; the full, dropped-last and overflowing batches
		// are placed among small ones.
		for (batch_no = 0; batch_no < 16; batch_no++) begin
			case (batch_no % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 83; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 83; end
				default: begin idle_pct = 30; stall_pct = 30; end
			endcase
			if (batch_no == 2) begin
				batch_len = CAP;
				idle_pct  = 0;
				hold_req  = 1'b1;
			end else if (batch_no == 7) begin
				batch_len = CAP + 1;
			end else if (batch_no == 12) begin
				batch_len = CAP + 3;
			end else begin
				batch_len = $urandom_range(1, 5);
			end
			for (n = 0; n < batch_len; n++)
				send_item(random_key(), TAG_BITS'($urandom), n == batch_len - 1);
		end
		s_tvalid <= 1'b0;

		while (pending_sorted.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d items in %0d batches, %0d with overflow; checked %0d sorted results.",
			items_sent, batches_done, overflow_batches, results_seen);
		$display("Covered ties, extreme keys, a full store, a dropped final item and a long stall.");
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
